/* sv/hotp_pkg.sv */
// Package for the HMAC-SHA1 one-time password validator.
// Shared constants, codes and the SHA-1 round helpers; no dependencies.
package hotp_pkg;

    localparam int CODE_DIGITS = 6;
    localparam int CODE_W      = 20;
    localparam int BIN_W       = 31;

    function automatic logic [31:0] pow10_fn(input int n);
        logic [31:0] r;
        r = 32'd1;
        for (int i = 0; i < 8; i++) begin
            if (i < n) begin
                r = r * 32'd10;
            end
        end
        return r;
    endfunction

    localparam logic [31:0] MODULUS = pow10_fn(CODE_DIGITS);

    // MODULUS << (MOD_SHIFT + 1) exceeds any 31-bit truncated value
    localparam logic [3:0] MOD_SHIFT = 4'd11;

    localparam logic [1:0] REG_KEY0 = 2'd0;
    localparam logic [1:0] REG_KEY1 = 2'd1;
    localparam logic [1:0] REG_KEY2 = 2'd2;
    localparam logic [1:0] REG_STEP = 2'd3;

    localparam logic [7:0] IPAD = 8'h36;
    localparam logic [7:0] OPAD = 8'h5c;

    localparam logic [159:0] SHA1_IV =
        160'h67452301_EFCDAB89_98BADCFE_10325476_C3D2E1F0;

    typedef struct packed {
        logic         start;
        logic         load_iv;
        logic [511:0] block;
    } sha_cmd_t;

    function automatic logic [31:0] round_k(input logic [6:0] i);
        logic [31:0] k;
        if (i < 7'd20) begin
            k = 32'h5A827999;
        end else if (i < 7'd40) begin
            k = 32'h6ED9EBA1;
        end else if (i < 7'd60) begin
            k = 32'h8F1BBCDC;
        end else begin
            k = 32'hCA62C1D6;
        end
        return k;
    endfunction

    function automatic logic [31:0] round_f(input logic [6:0] i, input logic [31:0] b,
                                            input logic [31:0] c, input logic [31:0] d);
        logic [31:0] f;
        if (i < 7'd20) begin
            f = (b & c) | (~b & d);
        end else if (i < 7'd40 || i >= 7'd60) begin
            f = b ^ c ^ d;
        end else begin
            f = (b & c) | (b & d) | (c & d);
        end
        return f;
    endfunction

endpackage

/* sv/hotp_sha1_core.sv */
// SHA-1 compression unit: one round per cycle, 16-word rolling schedule.
// Uses hotp_pkg; chains over blocks unless load_iv restarts from the IV.
module hotp_sha1_core (
    input  logic              aclk,
    input  logic              aresetn,
    input  hotp_pkg::sha_cmd_t cmd,
    output logic              busy,
    output logic              done,
    output logic [159:0]      digest
);

    logic [511:0] w_reg, w_next;
    logic [159:0] h_reg, h_next;
    logic [31:0]  a_reg, b_reg, c_reg, d_reg, e_reg;
    logic [31:0]  a_next, b_next, c_next, d_next, e_next;
    logic [6:0]   rnd_reg, rnd_next;
    logic         busy_reg, busy_next;
    logic         done_reg, done_next;
    logic [31:0]  wi, wn, t;
    logic [159:0] hs;

    assign busy   = busy_reg;
    assign done   = done_reg;
    assign digest = h_reg;
    assign wi     = w_reg[511:480];
    assign wn     = {w_reg[95:64] ^ w_reg[255:224] ^ w_reg[447:416] ^ w_reg[511:480]} ;
    assign t      = {a_reg[26:0], a_reg[31:27]} + hotp_pkg::round_f(rnd_reg, b_reg, c_reg, d_reg)
                    + e_reg + hotp_pkg::round_k(rnd_reg) + wi;
    assign hs     = cmd.load_iv ? hotp_pkg::SHA1_IV : h_reg;

    always_comb begin
        w_next = w_reg; h_next = h_reg; rnd_next = rnd_reg;
        busy_next = busy_reg; done_next = 1'b0;
        a_next = a_reg; b_next = b_reg; c_next = c_reg; d_next = d_reg; e_next = e_reg;
        if (!busy_reg && cmd.start) begin
            w_next = cmd.block; h_next = hs; rnd_next = '0; busy_next = 1'b1;
            a_next = hs[159:128]; b_next = hs[127:96]; c_next = hs[95:64];
            d_next = hs[63:32];   e_next = hs[31:0];
        end else if (busy_reg) begin
            w_next = {w_reg[479:0], wn[30:0], wn[31]};
            e_next = d_reg; d_next = c_reg; c_next = {b_reg[1:0], b_reg[31:2]};
            b_next = a_reg; a_next = t;
            rnd_next = rnd_reg + 7'd1;
            if (rnd_reg == 7'd79) begin
                busy_next = 1'b0; done_next = 1'b1;
                h_next = {h_reg[159:128] + t, h_reg[127:96] + a_reg,
                          h_reg[95:64] + {b_reg[1:0], b_reg[31:2]},
                          h_reg[63:32] + c_reg, h_reg[31:0] + d_reg};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0; done_reg <= 1'b0; rnd_reg <= '0;
        end else begin
            busy_reg <= busy_next; done_reg <= done_next; rnd_reg <= rnd_next;
        end
        w_reg <= w_next; h_reg <= h_next;
        a_reg <= a_next; b_reg <= b_next; c_reg <= c_next; d_reg <= d_next; e_reg <= e_next;
    end

`ifndef SYNTHESIS
    a_done_end: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> !busy_reg) else $error("done while busy");
    a_round: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> rnd_reg <= 7'd79) else $error("round overrun");
    a_fin: assert property (@(posedge aclk) disable iff (!aresetn)
        (busy_reg && rnd_reg == 7'd79) |=> done_reg) else $error("no done");
`endif

endmodule

/* sv/hotp_divider.sv */
// Restoring divider: one quotient bit per cycle, 64 by 32 bits.
// Self-contained; divides the time value by the time step.
module hotp_divider (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] dividend,
    input  logic [31:0] divisor,
    output logic        busy,
    output logic [63:0] quotient
);

    logic [63:0] q_reg, q_next;
    logic [32:0] r_reg, r_next;
    logic [31:0] d_reg, d_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic [32:0] sh, df;

    assign busy      = cnt_reg != 7'd0;
    assign quotient  = q_reg;
    assign sh        = {r_reg[31:0], q_reg[63]};
    assign df        = sh - {1'b0, d_reg};

    always_comb begin
        q_next = q_reg; r_next = r_reg; d_next = d_reg; cnt_next = cnt_reg;
        if (cnt_reg == 7'd0 && start) begin
            q_next = dividend; r_next = '0; d_next = divisor; cnt_next = 7'd64;
        end else if (cnt_reg != 7'd0) begin
            if (!df[32]) begin
                r_next = df; q_next = {q_reg[62:0], 1'b1};
            end else begin
                r_next = sh; q_next = {q_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg - 7'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
        q_reg <= q_next; r_reg <= r_next; d_reg <= d_next;
    end

`ifndef SYNTHESIS
    a_rem: assert property (@(posedge aclk) disable iff (!aresetn)
        busy |-> r_reg < {1'b0, d_reg} || d_reg == 32'd0) else $error("remainder range");
    a_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        busy |=> cnt_reg == $past(cnt_reg) - 7'd1) else $error("count step");
    a_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (!busy && start) |=> cnt_reg == 7'd64) else $error("start load");
`endif

endmodule

/* sv/hmac_sha1_otp_validator.sv */
// Top level of the HMAC-SHA1 HOTP/TOTP validator: sequencer, key registers.
// Uses hotp_pkg, hotp_sha1_core and hotp_divider.
//
//  channel | dir | handshake               | payload
//  s_      | in  | s_tvalid/s_tready        | s_tuser mode, s_tdata moving_value,candidate
//  m_      | out | m_tvalid/m_tready        | m_tuser valid_res, m_tdata computed_code
//  cfg_    | in  | cfg_valid/cfg_ready      | cfg_index, cfg_data
//
// An item is accepted, then passes a time divide (TOTP only), four SHA-1 blocks on
// the one round unit, a compare-and-subtract modulo and the output step.
// s_tready is high only in idle; the result waits in an output register, and the
// output cycle stalls while the previous item is still unaccepted.
// Reset (aresetn low, synchronous) clears the key to zero, step to 30.
module hmac_sha1_otp_validator (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [87:0] s_tdata,   // [63:0] moving_value, [83:64] candidate_code
    input  logic        s_tuser,   // [0] mode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [19:0] computed_code
    output logic        m_tuser,   // [0] valid_res
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data
);

    typedef enum logic [3:0] {
        ST_IDLE, ST_DIV, ST_DIVW, ST_HASH, ST_HASHW, ST_MOD, ST_MODW, ST_OUT
    } state_t;

    state_t       state_reg;
    logic [63:0]  key0_reg, key1_reg;
    logic [31:0]  key2_reg;
    logic [15:0]  step_reg;
    logic [63:0]  fact_reg;
    logic [19:0]  cand_reg;
    logic [1:0]   blk_reg;
    logic [159:0] inner_reg;
    logic         m_valid_reg, res_ok_reg;
    logic [19:0]  code_reg;
    logic [31:0]  rem_reg;
    logic [3:0]   msh_reg;

    hotp_pkg::sha_cmd_t cmd;
    logic         sha_busy, sha_done;
    logic [159:0] digest;
    logic         div_start, div_busy;
    logic [63:0]  div_a, div_q;
    logic [31:0]  div_b;
    logic [511:0] keyblk;
    logic [7:0]   pad;
    logic [3:0]   off;
    logic [31:0]  bin;
    logic [159:0] dsh;
    logic [42:0]  msub;

    assign s_tready  = state_reg == ST_IDLE;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = {4'd0, code_reg};
    assign m_tuser   = res_ok_reg;

    assign pad    = blk_reg[1] ? hotp_pkg::OPAD : hotp_pkg::IPAD;
    assign keyblk = {key0_reg, key1_reg, key2_reg, 352'd0} ^ {64{pad}};

    always_comb begin
        cmd.start   = state_reg == ST_HASH;
        cmd.load_iv = !blk_reg[0];
        case (blk_reg)
            2'd1:    cmd.block = {fact_reg, 8'h80, 376'd0, 64'd576};
            2'd3:    cmd.block = {inner_reg, 8'h80, 280'd0, 64'd672};
            default: cmd.block = keyblk;
        endcase
    end

    assign off = digest[3:0];
    assign dsh = digest << {off, 3'b000};
    assign bin = {1'b0, dsh[158:128]};

    assign msub = {11'd0, hotp_pkg::MODULUS} << msh_reg;

    assign div_start = state_reg == ST_DIV;
    assign div_a     = fact_reg;
    assign div_b     = step_reg == 16'd0 ? 32'd1 : {16'd0, step_reg};

    hotp_sha1_core u_sha (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd),
        .busy(sha_busy), .done(sha_done), .digest(digest)
    );

    hotp_divider u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start), .dividend(div_a),
        .divisor(div_b), .busy(div_busy), .quotient(div_q)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            key0_reg    <= '0;
            key1_reg    <= '0;
            key2_reg    <= '0;
            step_reg    <= 16'd30;
            m_valid_reg <= 1'b0;
            blk_reg     <= '0;
        end else begin
            if (cfg_valid) begin
                case (cfg_index)
                    hotp_pkg::REG_KEY0: key0_reg <= cfg_data;
                    hotp_pkg::REG_KEY1: key1_reg <= cfg_data;
                    hotp_pkg::REG_KEY2: key2_reg <= cfg_data[31:0];
                    hotp_pkg::REG_STEP: step_reg <= cfg_data[15:0];
                    default: ;
                endcase
            end
            if (state_reg == ST_OUT && (!m_valid_reg || m_tready)) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_tready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        fact_reg  <= s_tdata[63:0];
                        cand_reg  <= s_tdata[83:64];
                        blk_reg   <= '0;
                        state_reg <= s_tuser ? ST_DIV : ST_HASH;
                    end
                end
                ST_DIV:  state_reg <= ST_DIVW;
                ST_DIVW: begin
                    if (!div_busy) begin
                        fact_reg  <= div_q;
                        state_reg <= ST_HASH;
                    end
                end
                ST_HASH: state_reg <= ST_HASHW;
                ST_HASHW: begin
                    if (sha_done) begin
                        if (blk_reg == 2'd1) begin
                            inner_reg <= digest;
                        end
                        blk_reg   <= blk_reg + 2'd1;
                        state_reg <= blk_reg == 2'd3 ? ST_MOD : ST_HASH;
                    end
                end
                ST_MOD: begin
                    rem_reg   <= bin;
                    msh_reg   <= hotp_pkg::MOD_SHIFT;
                    state_reg <= ST_MODW;
                end
                ST_MODW: begin
                    if ({11'd0, rem_reg} >= msub) begin
                        rem_reg <= rem_reg - msub[31:0];
                    end
                    if (msh_reg == 4'd0) begin
                        state_reg <= ST_OUT;
                    end else begin
                        msh_reg <= msh_reg - 4'd1;
                    end
                end
                ST_OUT: begin
                    if (!m_valid_reg || m_tready) begin
                        code_reg   <= rem_reg[19:0];
                        res_ok_reg <= rem_reg == {12'd0, cand_reg};
                        state_reg  <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_busy_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_IDLE |-> !sha_busy) else $error("hash busy in idle");
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> m_tvalid && $stable(m_tdata)) else $error("out drop");
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready) else $error("ready after accept");
`endif

endmodule

/* tb/sv/tb_hmac_sha1_otp_validator.sv */
// Testbench for the HMAC-SHA1 HOTP/TOTP validator: directed table, then random items.
// Predicts codes with its own SHA-1/HMAC model; depends on hotp_pkg and the validator RTL.
module tb_hmac_sha1_otp_validator;

    typedef struct packed {
        logic        mode;
        logic [63:0] mval;
        logic [19:0] cand;
    } otp_req_t;

    typedef struct packed {
        logic        ok;
        logic [19:0] code;
    } otp_res_t;

    typedef struct {
        otp_req_t req;
        logic     fixed;
        otp_res_t res;
    } dir_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [87:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic        m_tuser;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [63:0] cfg_data = '0;

    logic [63:0] key_hi, key_mid;
    logic [31:0] key_lo;
    logic [15:0] step_reg;
    otp_res_t    code_q[$];
    int          n_err = 0;
    bit          rx_random = 1'b1;

    always #5 aclk = ~aclk;

    hmac_sha1_otp_validator dut (.*);

    function automatic logic [159:0] sha1_compress(logic [159:0] hin, logic [511:0] blk);
        logic [31:0] w[80];
        logic [31:0] a, b, c, d, e, f, k, t;
        for (int i = 0; i < 16; i++) w[i] = blk[511 - 32 * i -: 32];
        for (int i = 16; i < 80; i++) begin
            t = w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16];
            w[i] = {t[30:0], t[31]};
        end
        {a, b, c, d, e} = hin;
        for (int i = 0; i < 80; i++) begin
            if (i < 20) begin
                f = (b & c) | (~b & d); k = 32'h5A827999;
            end else if (i < 40) begin
                f = b ^ c ^ d; k = 32'h6ED9EBA1;
            end else if (i < 60) begin
                f = (b & c) | (b & d) | (c & d); k = 32'h8F1BBCDC;
            end else begin
                f = b ^ c ^ d; k = 32'hCA62C1D6;
            end
            t = {a[26:0], a[31:27]} + f + e + k + w[i];
            e = d; d = c; c = {b[1:0], b[31:2]}; b = a; a = t;
        end
        return {hin[159:128] + a, hin[127:96] + b, hin[95:64] + c,
                hin[63:32] + d, hin[31:0] + e};
    endfunction

    function automatic otp_res_t otp_predict(otp_req_t r);
        logic [511:0] kblk, ib, ob, tail;
        logic [159:0] h, inner, outer;
        logic [63:0]  fac;
        logic [31:0]  bin, modv;
        logic [3:0]   off;
        otp_res_t     res;
        kblk = {key_hi, key_mid, key_lo, 352'h0};
        ib = kblk ^ {64{hotp_pkg::IPAD}};
        ob = kblk ^ {64{hotp_pkg::OPAD}};
        fac = r.mval;
        if (r.mode) fac = fac / ((step_reg == 0) ? 64'd1 : 64'(step_reg));
        tail = {fac, 8'h80, 376'h0, 64'd576};
        h = sha1_compress(hotp_pkg::SHA1_IV, ib);
        inner = sha1_compress(h, tail);
        tail = {inner, 8'h80, 280'h0, 64'd672};
        h = sha1_compress(hotp_pkg::SHA1_IV, ob);
        outer = sha1_compress(h, tail);
        off = outer[3:0];
        bin = outer[159 - 8 * off -: 32];
        bin[31] = 1'b0;
        modv = 1;
        for (int i = 0; i < hotp_pkg::CODE_DIGITS; i++) modv = modv * 10;
        bin = bin % modv;
        res.ok = (bin == 32'(r.cand));
        res.code = bin[19:0];
        return res;
    endfunction

    task automatic cfg_write(logic [1:0] idx, logic [63:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            hotp_pkg::REG_KEY0: key_hi = val;
            hotp_pkg::REG_KEY1: key_mid = val;
            hotp_pkg::REG_KEY2: key_lo = val[31:0];
            hotp_pkg::REG_STEP: step_reg = val[15:0];
            default: ;
        endcase
        @(posedge aclk);
    endtask

    task automatic drain();
        while (code_q.size() != 0) @(posedge aclk);
        repeat (500) @(posedge aclk);
    endtask

    task automatic send_req(otp_req_t r);
        int gap;
        gap = ($urandom_range(9) == 0) ? $urandom_range(600) : $urandom_range(3);
        if ($urandom_range(3) == 0) gap = 0;
        repeat (gap) @(posedge aclk);
        s_tvalid <= 1'b1;
        s_tuser  <= r.mode;
        s_tdata  <= {4'h0, r.cand, r.mval};
        do @(posedge aclk); while (!s_tready);
        s_tvalid <= 1'b0;
        code_q.push_back(otp_predict(r));
        @(posedge aclk);
    endtask

    function automatic otp_req_t rand_req();
        otp_req_t r;
        r.mode = 1'($urandom_range(1));
        case ($urandom_range(3))
            0: r.mval = 64'($urandom_range(100));
            1: r.mval = {32'h0, $urandom};
            default: r.mval = {$urandom, $urandom};
        endcase
        r.cand = ($urandom_range(3) == 0) ? 20'($urandom) : 20'($urandom_range(999999));
        return r;
    endfunction

    always @(posedge aclk) begin
        otp_res_t exp_r;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (code_q.size() == 0) begin
                    n_err++;
                    if (n_err <= 10) $display("unexpected result %h/%b", m_tdata, m_tuser);
                end else begin
                    exp_r = code_q.pop_front();
                    if (m_tuser !== exp_r.ok || m_tdata !== {4'h0, exp_r.code}) begin
                        n_err++;
                        if (n_err <= 10)
                            $display("mismatch: exp code %0d ok %b, got code %0d ok %b",
                                     exp_r.code, exp_r.ok, m_tdata[19:0], m_tuser);
                    end
                end
            end
            if (!rx_random) m_tready <= 1'b1;
            else if ($urandom_range(15) == 0) m_tready <= ($urandom_range(4) == 0);
            else m_tready <= ($urandom_range(3) != 0);
        end
    end

    initial begin
        #50000000;
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        dir_row_t rows[$];
        dir_row_t row;
        otp_res_t got;
        key_hi = '0; key_mid = '0; key_lo = '0; step_reg = 16'd30;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed rows, zero key and default step
        row.fixed = 1'b0;
        row.req = '{1'b0, 64'd0, 20'd0};             rows.push_back(row);
        row.req = '{1'b0, 64'd1, 20'd999999};        rows.push_back(row);
        row.req = '{1'b0, '1, 20'hFFFFF};            rows.push_back(row);
        row.req = '{1'b1, '1, 20'd0};                rows.push_back(row);
        row.req = '{1'b1, 64'd59, 20'd123456};       rows.push_back(row);
        foreach (rows[i]) send_req(rows[i].req);
        // candidate equal to its own predicted code must match
        row.req = '{1'b0, 64'd7, 20'd0};
        got = otp_predict(row.req);
        row.req.cand = got.code;
        row.fixed = 1'b1; row.res = '{1'b1, got.code};
        if (otp_predict(row.req) !== row.res) n_err++;
        send_req(row.req);
        drain();

        // RFC 4226 test key with a couple of counters
        cfg_write(hotp_pkg::REG_KEY0, 64'h3132333435363738);
        cfg_write(hotp_pkg::REG_KEY1, 64'h3930313233343536);
        cfg_write(hotp_pkg::REG_KEY2, 64'h37383930);
        row.req = '{1'b0, 64'd0, 20'd755224}; row.res = '{1'b1, 20'd755224};
        if (otp_predict(row.req) !== row.res) n_err++;
        send_req(row.req);
        send_req('{1'b0, 64'd1, 20'd287082});
        send_req('{1'b1, 64'd59, 20'd0});
        drain();
        // zero step behaves as one
        cfg_write(hotp_pkg::REG_STEP, 64'd0);
        send_req('{1'b1, 64'd12345, 20'd0});
        send_req('{1'b1, '1, 20'd1});
        drain();
        cfg_write(hotp_pkg::REG_STEP, 64'hFFFF);
        send_req('{1'b1, '1, 20'd0});
        send_req('{1'b1, 64'd65534, 20'd0});
        drain();
        cfg_write(hotp_pkg::REG_KEY0, '1); cfg_write(hotp_pkg::REG_KEY1, '1);
        cfg_write(hotp_pkg::REG_KEY2, 64'hFFFFFFFF);
        cfg_write(hotp_pkg::REG_STEP, 64'd1);
        send_req('{1'b1, 64'd5, 20'd0});
        send_req('{1'b0, 64'h8000000000000000, 20'h80000});
        drain();

        for (int ph = 0; ph < 8; ph++) begin
            cfg_write(hotp_pkg::REG_KEY0, {$urandom, $urandom});
            cfg_write(hotp_pkg::REG_KEY1, {$urandom, $urandom});
            cfg_write(hotp_pkg::REG_KEY2, {32'h0, $urandom});
            cfg_write(hotp_pkg::REG_STEP, (ph == 0) ? 64'd1 : (ph == 1) ? 64'hFFFF :
                                          64'($urandom_range(65535)));
            rx_random = (ph != 3);
            for (int i = 0; i < 100; i++) begin
                otp_req_t r;
                r = rand_req();
                if ($urandom_range(4) == 0) begin
                    got = otp_predict(r);
                    r.cand = got.code;
                end
                send_req(r);
            end
            drain();
        end

        if (n_err == 0) $display("Simulation PASSED");
        else $display("Simulation FAILED");
        $finish;
    end
endmodule
